// ===== src/u8fc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8fc_pkg
// Shared types, constants and the accent lookup for the UTF-8 font decoder.
// ----------------------------------------------------------------------------
package u8fc_pkg;

    localparam int TABLE_LEN   = 30;
    localparam int MAP_ENTRIES = 30;
    localparam int MAP_USED    = (MAP_ENTRIES < TABLE_LEN) ? MAP_ENTRIES : TABLE_LEN;

    localparam logic [7:0] QMARK      = 8'd63;
    localparam logic [7:0] TERMINATOR = 8'd0;

    localparam logic [15:0] ACCENT_POINT [TABLE_LEN] = '{
        16'h00E1, 16'h00E0, 16'h00E2, 16'h00E3, 16'h00E9, 16'h00EA,
        16'h00ED, 16'h00F3, 16'h00F4, 16'h00F5, 16'h00FA, 16'h00E7,
        16'h00C1, 16'h00C0, 16'h00C2, 16'h00C3, 16'h00C9, 16'h00CA,
        16'h00CD, 16'h00D3, 16'h00D4, 16'h00D5, 16'h00DA, 16'h00C7,
        16'h00F1, 16'h00D1, 16'h00FC, 16'h00DC, 16'h00BF, 16'h00A1
    };

    localparam logic [7:0] ACCENT_FONT [TABLE_LEN] = '{
        8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135,
        8'd136, 8'd137, 8'd138, 8'd139, 8'd140, 8'd141,
        8'd142, 8'd143, 8'd144, 8'd145, 8'd146, 8'd147,
        8'd148, 8'd149, 8'd150, 8'd151, 8'd152, 8'd153,
        8'd154, 8'd155, 8'd156, 8'd157, 8'd158, 8'd159
    };

    typedef struct packed {
        logic [7:0] font_code;
        logic       last;
    } t_result;

    // Up to two results per source byte
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_dec_out;

    // Parallel compare against the table; the earliest entry wins
    function automatic logic [7:0] lookup_point(input logic [20:0] point);
        logic [7:0] font;
        font = QMARK;
        for (int k = TABLE_LEN - 1; k >= 0; k--) begin
            if (k < MAP_USED && point == {5'd0, ACCENT_POINT[k]}) begin
                font = ACCENT_FONT[k];
            end
        end
        return font;
    endfunction

endpackage

// ===== src/u8fc_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8fc_decode
// Sequence state and the single-pass decode of one held byte into 0..2 results.
// ----------------------------------------------------------------------------
module u8fc_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [7:0]         i_byte,
    input  logic [9:0]         i_max_chars,
    output u8fc_pkg::t_dec_out o_dec
);
    import u8fc_pkg::*;

    logic [1:0]  r_pending;
    logic [20:0] r_acc;
    logic [9:0]  r_chars;
    logic [1:0]  n_pending;
    logic [20:0] n_acc;
    logic [9:0]  n_chars;
    logic [20:0] acc_shift;
    logic        do_lead;
    logic        lead_hit;
    t_result     lead_res;
    t_dec_out    dec;

    assign acc_shift = {r_acc[14:0], i_byte[5:0]};

    always_comb begin
        dec       = '0;
        n_pending = r_pending;
        n_acc     = r_acc;
        n_chars   = r_chars;
        do_lead   = 1'b0;
        lead_hit  = 1'b0;
        lead_res  = '0;

        if (r_pending != 2'd0) begin
            if (i_byte[7:6] == 2'b10) begin
                n_acc     = acc_shift;
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    dec.count          = 2'd1;
                    dec.res0.font_code = lookup_point(acc_shift);
                    n_chars            = r_chars + 10'd1;
                    n_acc              = '0;
                end
            end else begin
                // sequence cut short: '?' and the byte goes round again as a lead
                dec.count          = 2'd1;
                dec.res0.font_code = QMARK;
                n_chars            = r_chars + 10'd1;
                n_pending          = 2'd0;
                n_acc              = '0;
                do_lead            = 1'b1;
            end
        end else begin
            do_lead = 1'b1;
        end

        if (do_lead) begin
            if (i_byte == 8'd0) begin
                lead_hit  = 1'b1;
                lead_res  = '{font_code: TERMINATOR, last: 1'b1};
                n_chars   = '0;
                n_pending = 2'd0;
                n_acc     = '0;
            end else if (n_chars >= i_max_chars) begin
                lead_hit = 1'b0;
            end else if (i_byte[7] == 1'b0) begin
                lead_hit = 1'b1;
                lead_res = '{font_code: i_byte, last: 1'b0};
                n_chars  = n_chars + 10'd1;
            end else if (i_byte[7:5] == 3'b110) begin
                n_acc     = {16'd0, i_byte[4:0]};
                n_pending = 2'd1;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_acc     = {17'd0, i_byte[3:0]};
                n_pending = 2'd2;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_acc     = {18'd0, i_byte[2:0]};
                n_pending = 2'd3;
            end else begin
                lead_hit = 1'b1;
                lead_res = '{font_code: QMARK, last: 1'b0};
                n_chars  = n_chars + 10'd1;
            end

            if (lead_hit) begin
                if (dec.count == 2'd0) begin
                    dec.res0 = lead_res;
                end else begin
                    dec.res1 = lead_res;
                end
                dec.count = dec.count + 2'd1;
            end
        end
    end

    assign o_dec = dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_acc     <= '0;
            r_chars   <= '0;
        end else if (i_take) begin
            r_pending <= n_pending;
            r_acc     <= n_acc;
            r_chars   <= n_chars;
        end
    end

endmodule

// ===== src/u8fc_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8fc_out_queue
// Two-entry result queue; takes one or two results a cycle, head is registered.
// ----------------------------------------------------------------------------
module u8fc_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_count,
    input  u8fc_pkg::t_result i_data0,
    input  u8fc_pkg::t_result i_data1,
    input  logic              i_pop,
    output logic [1:0]        o_room,
    output logic              o_valid,
    output u8fc_pkg::t_result o_head
);
    import u8fc_pkg::*;

    logic [1:0] r_count;
    t_result    r_slot0;
    t_result    r_slot1;
    logic [1:0] n_count;
    t_result    n_slot0;
    t_result    n_slot1;
    logic [1:0] kept;

    // room counts the entry leaving this cycle
    assign kept   = r_count - {1'b0, i_pop};
    assign o_room = 2'd2 - kept;

    always_comb begin
        n_slot0 = i_pop ? r_slot1 : r_slot0;
        n_slot1 = r_slot1;
        if (i_push_count != 2'd0) begin
            if (kept == 2'd0) begin
                n_slot0 = i_data0;
            end else begin
                n_slot1 = i_data0;
            end
        end
        if (i_push_count == 2'd2) begin
            n_slot1 = i_data1;
        end
        n_count = kept + i_push_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_slot0;

endmodule

// ===== src/utf8_to_font_code_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_font_code_decoder_top
// UTF-8 byte stream to font codes, with accent mapping and a length limit.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   in      | sink      | i_in_valid/o_in_stall  | i_in_byte
//   out     | source    | o_out_valid/i_out_stall| o_font_code, o_last
//   cfg     | sink      | i_cfg_valid/o_cfg_ready| i_cfg_data (max_chars)
//
// One byte a cycle when not stalled for queue room: input register, one decode
// pass, two-entry result queue. The result queue head is registered.
// A byte giving two results leaves the queue full at full output rate; the next
// such byte then stalls until room frees, so each extra result holds back input.
// Reset is synchronous; max_chars returns to 63 and all sequence state clears.
// ----------------------------------------------------------------------------
module utf8_to_font_code_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_font_code,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [9:0] i_cfg_data
);
    import u8fc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [9:0] r_max_chars;
    logic       take;
    logic       pop;
    logic [1:0] room;
    t_dec_out   dec;
    t_result    head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= 10'd63;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_chars <= i_cfg_data;
        end
    end

    assign pop        = o_out_valid && !i_out_stall;
    assign take       = r_in_valid && (room >= dec.count);
    assign o_in_stall = r_in_valid && !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_in_byte;
        end
    end

    u8fc_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (r_in_byte),
        .i_max_chars (r_max_chars),
        .o_dec       (dec)
    );

    u8fc_out_queue u_out_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (take ? dec.count : 2'd0),
        .i_data0      (dec.res0),
        .i_data1      (dec.res1),
        .i_pop        (pop),
        .o_room       (room),
        .o_valid      (o_out_valid),
        .o_head       (head)
    );

    assign o_font_code = head.font_code;
    assign o_last      = head.last;

    // held byte must survive a stall in the decode stage
    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !take) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("decode stage lost its byte while stalled");

    a_last_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_font_code == TERMINATOR))
        else $error("terminator result carries a non-zero code");

    a_empty_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> (room == 2'd2))
        else $error("empty queue reports less than full room");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (dec.count <= room))
        else $error("decode pushed more results than the queue holds");

endmodule
